// ----- design/cdrs_pkg.sv -----
`timescale 1ns / 1ps

package cdrs_pkg;

  // request kinds as they arrive on the input side
  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_REFRESH = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_CMD     = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic {
    REG_SHORT_WAIT = 1'b0,
    REG_LONG_WAIT  = 1'b1
  } cfg_reg_e;

  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 4;

  localparam logic [15:0] ShortWaitReset = 16'd1200;
  localparam logic [15:0] LongWaitReset  = 16'd4000;

  // clear-display command, the only one with the long wait
  localparam logic [7:0] CmdClear = 8'h01;

  // cursor command for the first character of each line
  localparam logic [7:0] LineCmd [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

  typedef struct packed {
    kind_e      kind;
    logic [1:0] row;
    logic [4:0] col;
    logic [7:0] data;
    logic       rs;
    logic       rw;
  } item_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic [7:0] data;
    logic       long_wait;
    logic       done;
  } frame_t;

endpackage

// ----- design/cdrs_front.sv -----
`timescale 1ns / 1ps

module cdrs_front import cdrs_pkg::*; #(
  parameter int unsigned ROWS = 4,
  parameter int unsigned COLS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind_i,
  input  logic [1:0] row_i,
  input  logic [4:0] col_i,
  input  logic [7:0] byte_in_i,
  input  logic       cmd_rs_i,
  input  logic       cmd_rw_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_pop_i
);

  localparam int unsigned PtrW = (MidDepth > 1) ? $clog2(MidDepth) : 1;
  localparam int unsigned CntW = $clog2(MidDepth + 1);

  item_t            mem_q [MidDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  item_t            item;
  logic             keep;
  logic             wr_en;
  logic             rd_en;

  // classify: writes outside the store are dropped here
  always_comb begin
    item.kind = kind_e'(kind_i);
    item.row  = row_i;
    item.col  = col_i;
    item.data = byte_in_i;
    item.rs   = cmd_rs_i;
    item.rw   = cmd_rw_i;
    keep = !((item.kind == KIND_WRITE) &&
             ((int'(row_i) >= int'(ROWS)) || (int'(col_i) >= int'(COLS))));
  end

  assign full         = (cnt_q == CntW'(MidDepth));
  assign wr_en        = push && !full && keep;
  assign rd_en        = item_pop_i && (cnt_q != '0);
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(MidDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(MidDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ----- design/cdrs_back.sv -----
`timescale 1ns / 1ps

module cdrs_back import cdrs_pkg::*; #(
  parameter int unsigned ROWS = 4,
  parameter int unsigned COLS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          item_valid_i,
  input  item_t                         item_i,
  output logic                          item_pop_o,
  input  logic [$clog2(OutDepth+1)-1:0] out_cnt_i,
  output logic                          res_valid_o,
  output frame_t                        res_o
);

  localparam int unsigned Depth = ROWS * COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]       rd_data_q;
  logic             rd_vld_q;

  logic [15:0] short_q, short_d;
  logic [15:0] long_q, long_d;
  logic [15:0] busy_q, busy_d;
  logic [1:0]  cur_row_q, cur_row_d;
  logic [4:0]  cur_col_q, cur_col_d;
  logic        active_q, active_d;
  logic        cursor_q, cursor_d;
  logic        pend_valid_q, pend_valid_d;
  logic        pend_rs_q, pend_rs_d;
  logic        pend_rw_q, pend_rw_d;
  logic [7:0]  pend_byte_q, pend_byte_d;
  logic        b_valid_q, b_valid_d;
  logic        b_char_q, b_char_d;
  frame_t      b_frame_q, b_frame_d;

  logic             go;
  logic             mem_we;
  logic             rd_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic             last_col;
  logic             last_row;

  // only start an item when its result is sure to find room downstream
  assign go = item_valid_i &&
              ((int'(out_cnt_i) + int'(b_valid_q)) < int'(OutDepth));
  assign item_pop_o = go;

  assign wr_addr  = AddrW'(int'(item_i.row) * int'(COLS) + int'(item_i.col));
  assign rd_addr  = AddrW'(int'(cur_row_q) * int'(COLS) + int'(cur_col_q));
  assign last_col = (int'(cur_col_q) + 1) >= int'(COLS);
  assign last_row = (int'(cur_row_q) + 1) >= int'(ROWS);

  always_comb begin
    short_d      = short_q;
    long_d       = long_q;
    busy_d       = busy_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    active_d     = active_q;
    cursor_d     = cursor_q;
    pend_valid_d = pend_valid_q;
    pend_rs_d    = pend_rs_q;
    pend_rw_d    = pend_rw_q;
    pend_byte_d  = pend_byte_q;
    b_valid_d    = 1'b0;
    b_char_d     = b_char_q;
    b_frame_d    = b_frame_q;
    mem_we       = 1'b0;
    rd_en        = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SHORT_WAIT: short_d = cfg_data_i;
        REG_LONG_WAIT:  long_d  = cfg_data_i;
        default: ;
      endcase
    end

    if (go) begin
      case (item_i.kind)
        KIND_WRITE: begin
          mem_we = 1'b1;
        end
        KIND_REFRESH: begin
          active_d  = 1'b1;
          cursor_d  = 1'b1;
          cur_row_d = '0;
          cur_col_d = '0;
        end
        KIND_CMD: begin
          if (!pend_valid_q) begin
            pend_valid_d = 1'b1;
            pend_rs_d    = item_i.rs;
            pend_rw_d    = item_i.rw;
            pend_byte_d  = item_i.data;
          end
        end
        KIND_TICK: begin
          if (busy_q != '0) begin
            busy_d = busy_q - 1'b1;
          end else if (pend_valid_q) begin
            pend_valid_d        = 1'b0;
            b_valid_d           = 1'b1;
            b_char_d            = 1'b0;
            b_frame_d.rs        = pend_rs_q;
            b_frame_d.rw        = pend_rw_q;
            b_frame_d.data      = pend_byte_q;
            b_frame_d.long_wait = (pend_byte_q == CmdClear);
            b_frame_d.done      = 1'b0;
            busy_d = (pend_byte_q == CmdClear) ? long_q : short_q;
          end else if (active_q && cursor_q) begin
            cursor_d            = 1'b0;
            b_valid_d           = 1'b1;
            b_char_d            = 1'b0;
            b_frame_d.rs        = 1'b0;
            b_frame_d.rw        = 1'b0;
            b_frame_d.data      = LineCmd[cur_row_q];
            b_frame_d.long_wait = (LineCmd[cur_row_q] == CmdClear);
            b_frame_d.done      = 1'b0;
            busy_d = (LineCmd[cur_row_q] == CmdClear) ? long_q : short_q;
          end else if (active_q) begin
            // character byte comes from the registered store read, together with the frame
            rd_en               = 1'b1;
            b_valid_d           = 1'b1;
            b_char_d            = 1'b1;
            b_frame_d.rs        = 1'b1;
            b_frame_d.rw        = 1'b0;
            b_frame_d.data      = '0;
            b_frame_d.long_wait = 1'b0;
            b_frame_d.done      = last_row && last_col;
            busy_d              = short_q;
            if (last_row && last_col) begin
              active_d = 1'b0;
            end else if (last_col) begin
              cur_row_d = cur_row_q + 1'b1;
              cur_col_d = '0;
              cursor_d  = 1'b1;
            end else begin
              cur_col_d = cur_col_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q      <= ShortWaitReset;
      long_q       <= LongWaitReset;
      busy_q       <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      active_q     <= 1'b0;
      cursor_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_rs_q    <= 1'b0;
      pend_rw_q    <= 1'b0;
      pend_byte_q  <= '0;
      b_valid_q    <= 1'b0;
      b_char_q     <= 1'b0;
      vld_q        <= '0;
      rd_vld_q     <= 1'b0;
    end else begin
      short_q      <= short_d;
      long_q       <= long_d;
      busy_q       <= busy_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      active_q     <= active_d;
      cursor_q     <= cursor_d;
      pend_valid_q <= pend_valid_d;
      pend_rs_q    <= pend_rs_d;
      pend_rw_q    <= pend_rw_d;
      pend_byte_q  <= pend_byte_d;
      b_valid_q    <= b_valid_d;
      b_char_q     <= b_char_d;
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // character store, no reset: unwritten entries read as zero via vld_q
  always_ff @(posedge clk_i) begin
    b_frame_q <= b_frame_d;
    if (mem_we) begin
      mem_q[wr_addr] <= item_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    res_o = b_frame_q;
    if (b_char_q) begin
      res_o.data = rd_vld_q ? rd_data_q : 8'h00;
    end
  end

  assign res_valid_o = b_valid_q;

endmodule

// ----- design/cdrs_out_fifo.sv -----
`timescale 1ns / 1ps

module cdrs_out_fifo import cdrs_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_valid_i,
  input  frame_t                        res_i,
  output logic [$clog2(OutDepth+1)-1:0] cnt_o,
  output logic                          empty,
  input  logic                          pop,
  output frame_t                        head_o
);

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  frame_t          mem_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rd_en;

  assign empty  = (cnt_q == '0);
  assign rd_en  = pop && !empty;
  assign cnt_o  = cnt_q;
  assign head_o = mem_q[rd_ptr_q];

  // the back end never pushes without room, so no full check here
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (res_valid_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (res_valid_i && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !res_valid_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ----- design/char_display_refresh_sequencer.sv -----
// a tick that sends a frame is registered in the back end, then written into the result queue
// throughput: one request per cycle, set by the back end state updating as each request
//   is taken and its one store access per request; requests stall only while the result queue,
//   counting a frame still on its way in, holds four frames
// reset (async, active low): empty queues, store reads as zero, refresh idle,
//   display ready, wait registers at 1200 and 4000 ticks
`timescale 1ns / 1ps

module char_display_refresh_sequencer import cdrs_pkg::*; #(
  parameter int unsigned ROWS = 4,
  parameter int unsigned COLS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  row_i,
  input  logic [4:0]  col_i,
  input  logic [7:0]  byte_in_i,
  input  logic        cmd_rs_i,
  input  logic        cmd_rw_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic        frame_rs_o,
  output logic        frame_rw_o,
  output logic [7:0]  frame_byte_o,
  output logic        long_wait_o,
  output logic        refresh_done_o
);

  item_t                         item;
  logic                          item_valid;
  logic                          item_pop;
  logic [$clog2(OutDepth+1)-1:0] out_cnt;
  logic                          res_valid;
  frame_t                        res;
  frame_t                        head;

  // the user is to change registers only between requests; the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // front end: takes requests, drops writes outside the store and
  // buffers the rest in a two-entry queue
  cdrs_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .byte_in_i    (byte_in_i),
    .cmd_rs_i     (cmd_rs_i),
    .cmd_rw_i     (cmd_rw_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // back end: character store, busy countdown, pending command and
  // refresh cursor; a character frame picks its byte up from the
  // store read that is registered alongside the frame
  cdrs_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_cnt_i    (out_cnt),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result queue decouples the display side from request processing
  cdrs_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .cnt_o       (out_cnt),
    .empty       (empty),
    .pop         (pop),
    .head_o      (head)
  );

  assign frame_rs_o     = head.rs;
  assign frame_rw_o     = head.rw;
  assign frame_byte_o   = head.data;
  assign long_wait_o    = head.long_wait;
  assign refresh_done_o = head.done;

endmodule

// ----- design/cdrs_checker.sv -----
`timescale 1ns / 1ps

module cdrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        frame_rs_o,
  input logic        frame_rw_o,
  input logic [7:0]  frame_byte_o,
  input logic        long_wait_o,
  input logic        refresh_done_o
);

  // last character of a refresh is a plain character write
  a_done_is_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && refresh_done_o |-> frame_rs_o && !frame_rw_o && !long_wait_o)
    else $error("refresh done on a frame that is not a character");

  // long wait only after clear display
  a_long_is_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && long_wait_o |-> frame_byte_o == 8'h01)
    else $error("long wait on a frame other than clear display");

  // input queue only fills through requests
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full && !push |=> !full)
    else $error("full rose without a request");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(frame_byte_o) && $stable(frame_rs_o) &&
      $stable(frame_rw_o) && $stable(long_wait_o) && $stable(refresh_done_o))
    else $error("waiting result changed before it was taken");

endmodule

bind char_display_refresh_sequencer cdrs_checker u_checker (.*);
